### hw/rtl/iprt_pkg.sv
package iprt_pkg;

  // Default number of routes the table holds.
  localparam int unsigned TableDepthDefault = 8;

  // A route with this metric is stored but can never be chosen.
  localparam logic [7:0] COST_LIMIT = 8'd255;

  // Item kind carried on the input tuser.
  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // One route. The first member sits in the top bits, so the address lands
  // in bits [31:0] and the interface number in bits [111:104].
  typedef struct packed {
    logic [7:0]  port;
    logic [7:0]  cost;
    logic [31:0] gateway;
    logic [31:0] mask;
    logic [31:0] address;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

### hw/rtl/ipv4_route_table_lookup.sv
// IPv4 route table with lowest-metric lookup. Each input beat is an add (tuser
// = 0) or a lookup (tuser = 1), and each gives exactly one output beat. An add
// writes its route and then has its result loaded through the done state, or
// reports ok = 0 when the table is full. A lookup reads the stored routes from
// a memory with one write port and one registered read port, one per cycle,
// oldest first; on an empty table it goes straight to the done state. The
// input is ready again once a result is loaded, so no new beat is taken while
// an add or a lookup is in progress. The earliest route with the lowest metric
// below 255 whose masked address equals the masked destination wins; the
// output then carries ok = 1 and the route, otherwise ok = 0 and zero fields.
// A finished result waits in the output register, and the next beat is taken
// while it does. Routes are never removed; only reset empties the table. The
// table needs no clearing pass.
module ipv4_route_table_lookup #(
  parameter int unsigned TABLE_DEPTH = iprt_pkg::TableDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [31:0] address, [63:32] mask, [95:64] gateway, [103:96] cost,
  // [111:104] port_number
  input  logic [iprt_pkg::EntryW-1:0] s_axis_tdata_i,
  // [0] func
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [31:0] hop_address, [63:32] hop_mask, [95:64] hop_gateway,
  // [103:96] hop_cost, [111:104] hop_port
  output logic [iprt_pkg::EntryW-1:0] m_axis_tdata_o,
  // [0] ok
  output logic                         m_axis_tuser_o
);

  import iprt_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] used_q, used_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            found_q, found_d;
  entry_t          best_q, best_d;
  logic [31:0]     addr_q, addr_d;
  logic            m_valid_q, m_valid_d;
  entry_t          m_data_q, m_data_d;
  logic            m_user_q, m_user_d;

  // Route memory: one write port (add), one registered read port (scan).
  entry_t          mem_q [TABLE_DEPTH];
  entry_t          rd_q;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] wr_idx;
  logic            wr_en;

  logic            accept;
  logic            is_lookup;
  logic [CntW-1:0] last_idx;
  logic            at_last;
  logic            hit;
  logic [7:0]      cost_bound;
  logic            take;
  logic            out_free;

  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    accept          = s_axis_tvalid_i && s_axis_tready_o;
    is_lookup       = (s_axis_tuser_i == FUNC_LOOKUP);
    wr_en           = accept && !is_lookup && (used_q < CntW'(TABLE_DEPTH));
    wr_idx          = used_q[IdxW-1:0];

    last_idx = CntW'(used_q - CntW'(1));
    at_last  = (CntW'(cmp_idx_q) == last_idx);
    // Prefetch the next route while the current one is compared.
    if (state_q == ST_SCAN && !at_last) begin
      rd_idx = IdxW'(cmp_idx_q + IdxW'(1));
    end else begin
      rd_idx = '0;
    end

    hit        = (((rd_q.address ^ addr_q) & rd_q.mask) == 32'd0);
    cost_bound = found_q ? best_q.cost : COST_LIMIT;
    take       = hit && (rd_q.cost < cost_bound);
    out_free   = !m_valid_q || m_axis_tready_i;
  end

  // Adds only happen while idle and a scan reads only stored routes, so a
  // write never lands on an entry that a scan reads.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= entry_t'(s_axis_tdata_i);
    end
    rd_q <= mem_q[rd_idx];
  end

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    cmp_idx_d = cmp_idx_q;
    found_d   = found_q;
    best_d    = best_q;
    addr_d    = addr_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          best_d    = '0;
          cmp_idx_d = '0;
          if (is_lookup) begin
            found_d = 1'b0;
            addr_d  = s_axis_tdata_i[31:0];
            state_d = (used_q == '0) ? ST_DONE : ST_SCAN;
          end else begin
            found_d = wr_en;
            if (wr_en) begin
              used_d = CntW'(used_q + CntW'(1));
            end
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        // Strict less-than keeps the earliest route on equal metrics.
        if (take) begin
          found_d = 1'b1;
          best_d  = rd_q;
        end
        if (at_last) begin
          state_d = ST_DONE;
        end else begin
          cmp_idx_d = IdxW'(cmp_idx_q + IdxW'(1));
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = best_q;
          m_user_d  = found_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      cmp_idx_q <= '0;
      found_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      cmp_idx_q <= cmp_idx_d;
      found_q   <= found_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q   <= best_d;
    addr_q   <= addr_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(TABLE_DEPTH))
    else $error("route count exceeds table depth");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |->
      (used_q == CntW'($past(used_q) + CntW'(1))) && $past(wr_en))
    else $error("route count moved without an add");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (used_q != '0) && (CntW'(cmp_idx_q) < used_q))
    else $error("scan index outside stored routes");

  // An add that stored its route leaves found set with an all-zero route.
  a_found_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && found_q) |->
      (best_q.cost != COST_LIMIT) || (best_q == '0))
    else $error("chosen route has the excluded metric");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside the done state");
`endif

endmodule

### tb/route_lookup_checker.sv
// Scoreboard for ipv4_route_table_lookup: keeps its own copy of the route
// table, predicts one result beat per accepted input beat and compares the
// result beats in order.
module route_lookup_checker #(
  parameter int unsigned TABLE_DEPTH = iprt_pkg::TableDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  input  logic                        s_axis_tready_i,
  input  logic [iprt_pkg::EntryW-1:0] s_axis_tdata_i,
  input  logic                        s_axis_tuser_i,
  input  logic                        m_axis_tvalid_i,
  input  logic                        m_axis_tready_i,
  input  logic [iprt_pkg::EntryW-1:0] m_axis_tdata_i,
  input  logic                        m_axis_tuser_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import iprt_pkg::*;

  typedef struct packed {
    logic   ok;
    entry_t route;
  } hop_result_t;

  entry_t      route_tbl [TABLE_DEPTH];
  int unsigned routes_used = 0;
  hop_result_t expected_hops [$];
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  // Add appends or fails when full; lookup takes the earliest route with the
  // lowest metric below the limit whose masked address matches.
  function automatic hop_result_t next_hop_for(input logic func, input entry_t item);
    hop_result_t res;
    int unsigned best;
    res  = '0;
    best = COST_LIMIT;
    if (func == FUNC_ADD) begin
      if (routes_used < TABLE_DEPTH) begin
        route_tbl[routes_used] = item;
        routes_used++;
        res.ok = 1'b1;
      end
    end else begin
      for (int unsigned i = 0; i < routes_used; i++) begin
        if ((route_tbl[i].address & route_tbl[i].mask) ==
            (item.address & route_tbl[i].mask) && route_tbl[i].cost < best) begin
          best      = route_tbl[i].cost;
          res.ok    = 1'b1;
          res.route = route_tbl[i];
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  always @(posedge clk_i) begin : monitor
    hop_result_t want;
    entry_t      got;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = entry_t'(m_axis_tdata_i);
        if (expected_hops.size() == 0) begin
          report_mismatch("result beat with nothing pending");
        end else begin
          want = expected_hops.pop_front();
          check_field("ok", 32'(m_axis_tuser_i), 32'(want.ok));
          check_field("hop_address", got.address, want.route.address);
          check_field("hop_mask", got.mask, want.route.mask);
          check_field("hop_gateway", got.gateway, want.route.gateway);
          check_field("hop_cost", 32'(got.cost), 32'(want.route.cost));
          check_field("hop_port", 32'(got.port), 32'(want.route.port));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_hops.push_back(next_hop_for(s_axis_tuser_i, entry_t'(s_axis_tdata_i)));
      end
      pending_o <= expected_hops.size();
    end
  end

endmodule

### tb/tb_ipv4_route_table_lookup.sv
// Stimulus and verdict for ipv4_route_table_lookup. Prediction and compare
// live in route_lookup_checker.
module tb_ipv4_route_table_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import iprt_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1530;
  // Watchdog limit, set with wide margin over the slowest correct run.
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES    = 20;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Input side: every input known from time zero.
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  entry_t            s_tdata  = '0;
  logic              s_tuser  = FUNC_ADD;

  // Output side.
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [EntryW-1:0] m_tdata;
  logic              m_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles     = 0;
  int unsigned burst_left = 0;
  bit          rx_hold_req = 1'b0;   // asks the receiver for one long hold-off

  // Routes loaded by the directed part; random lookups aim at them.
  entry_t route_plan [8];

  always #2 clk = ~clk;

  ipv4_route_table_lookup u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  route_lookup_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ipv4_route_table_lookup test failed");
      $finish;
    end
  end

  // Receiver: tready follows a duty cycle that changes every segment
  // (some segments always ready); on request it holds off for a long
  // stretch so the output register fills and the input stalls.
  initial begin : rx_stall
    int unsigned ready_pct;
    int unsigned seg_left;
    int unsigned hold_left;
    ready_pct = 100;
    seg_left  = 0;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = RX_HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        case ($urandom_range(3))
          0:       ready_pct = 100;
          1:       ready_pct = 70;
          2:       ready_pct = 40;
          default: ready_pct = 10;
        endcase
        seg_left = $urandom_range(200, 20);
      end
      seg_left--;
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) < ready_pct);
      end
    end
  end

  function automatic entry_t make_route(input logic [31:0] addr, input logic [31:0] mask,
                                        input logic [31:0] gw, input logic [7:0] cost,
                                        input logic [7:0] port);
    entry_t e;
    e.address = addr;
    e.mask    = mask;
    e.gateway = gw;
    e.cost    = cost;
    e.port    = port;
    return e;
  endfunction

  // Lookup beat: only the address counts, the rest is junk the block ignores.
  function automatic entry_t lookup_of(input logic [31:0] dest);
    return make_route(dest, $urandom, $urandom, 8'($urandom_range(255)),
                      8'($urandom_range(255)));
  endfunction

  // Sender works in bursts; a gap of random length may precede each burst.
  // Drives at the clock edge and returns on the edge that takes the beat.
  task automatic push_beat(input logic func, input entry_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(7) == 0) ? 0 : $urandom_range(12, 1);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(120, 40) : $urandom_range(6, 1);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= item;
    do @(posedge clk); while (!s_tready);
  endtask

  // Sender goes quiet until every result beat has come back.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int unsigned pick;
    logic [31:0] dest;
    entry_t      aim;

    // Table contents: equal metrics, unmasked host bits, a catch-all that
    // can never win (metric 255, mask 0), a host route with metric 0.
    route_plan[0] = make_route(32'h0A00_0000, 32'hFF00_0000, 32'h0000_0000, 8'd10,  8'd1);
    route_plan[1] = make_route(32'h0A01_01FF, 32'hFFFF_0000, 32'hFFFF_FFFF, 8'd10,  8'd2);
    route_plan[2] = make_route(32'h0A02_0000, 32'hFFFF_0000, 32'h0A00_0001, 8'd5,   8'd3);
    route_plan[3] = make_route(32'hC0A8_0100, 32'h0000_0000, 32'hC0A8_0001, 8'd255, 8'd4);
    route_plan[4] = make_route(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 8'd0,   8'd255);
    route_plan[5] = make_route(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 8'd200, 8'd0);
    route_plan[6] = make_route(32'hAC10_0000, 32'hFFF0_0000, 32'hDEAD_BEEF, 8'd254, 8'd7);
    route_plan[7] = make_route(32'h0A02_0000, 32'hFFFF_0000, 32'h0A00_0002, 8'd5,   8'd128);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    push_beat(FUNC_LOOKUP, lookup_of(32'hFFFF_FFFF));        // empty table
    for (int i = 0; i < 5; i++) push_beat(FUNC_ADD, route_plan[i]);
    push_beat(FUNC_LOOKUP, lookup_of(32'h0102_0304));        // only the 255 route matches
    push_beat(FUNC_LOOKUP, lookup_of(32'h0A01_0203));        // tie at 10, older wins
    push_beat(FUNC_LOOKUP, lookup_of(32'h0A02_FFFF));        // lower metric beats /8
    push_beat(FUNC_LOOKUP, lookup_of(32'hFFFF_FFFF));        // host route, metric 0
    for (int i = 5; i < 8; i++) push_beat(FUNC_ADD, route_plan[i]);
    push_beat(FUNC_ADD, make_route('1, '1, '1, 8'hFF, 8'hFF)); // table full
    push_beat(FUNC_ADD, make_route('0, '0, '0, 8'h00, 8'h00)); // table full
    push_beat(FUNC_LOOKUP, lookup_of(32'h0A02_0304));        // tie at 5, older wins
    push_beat(FUNC_LOOKUP, lookup_of(32'h0000_0000));        // lower-half route
    push_beat(FUNC_LOOKUP, lookup_of(32'hAC1F_FFFF));        // metric 254 still valid
    push_beat(FUNC_LOOKUP, lookup_of(32'hFFFF_FFFE));        // only the 255 route matches
    push_beat(FUNC_LOOKUP, make_route(32'h0A00_00FF, '1, '1, 8'hFF, 8'hFF));
    wait_for_results();

    // Random part: mostly lookups aimed inside a stored prefix with random
    // host bits, plus random destinations and adds that bounce off the full
    // table.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) rx_hold_req = 1'b1;
      if (n == 900) wait_for_results();
      pick = $urandom_range(99);
      if (pick < 10) begin
        push_beat(FUNC_ADD, make_route($urandom, $urandom, $urandom,
                                       8'($urandom_range(255)), 8'($urandom_range(255))));
      end else if (pick < 65) begin
        aim  = route_plan[$urandom_range(7)];
        dest = (aim.address & aim.mask) | ($urandom & ~aim.mask);
        push_beat(FUNC_LOOKUP, lookup_of(dest));
      end else if (pick < 70) begin
        push_beat(FUNC_LOOKUP, lookup_of($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0));
      end else begin
        push_beat(FUNC_LOOKUP, lookup_of($urandom));
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ipv4_route_table_lookup test passed");
    end else begin
      $display("ipv4_route_table_lookup test failed");
    end
    $finish;
  end

endmodule
